// ----- sv/fplc_pkg.sv -----
// types and constants shared by the frame plane layout calculator
// request and result items, pipeline metadata, format codes and internal widths
// no dependencies
`default_nettype none

package fplc_pkg;

    // pixel format codes
    localparam logic [3:0] FMT_RGB24  = 4'd0;
    localparam logic [3:0] FMT_BGR24  = 4'd1;
    localparam logic [3:0] FMT_ARGB32 = 4'd2;
    localparam logic [3:0] FMT_ABGR32 = 4'd3;
    localparam logic [3:0] FMT_Y416   = 4'd4;
    localparam logic [3:0] FMT_YUY2   = 4'd5;
    localparam logic [3:0] FMT_UYVY   = 4'd6;
    localparam logic [3:0] FMT_Y800   = 4'd7;
    localparam logic [3:0] FMT_YV12   = 4'd8;
    localparam logic [3:0] FMT_I420   = 4'd9;
    localparam logic [3:0] FMT_YV24   = 4'd10;
    localparam logic [3:0] FMT_NV12   = 4'd11;
    localparam logic [3:0] FMT_P010   = 4'd12;
    localparam logic [3:0] FMT_P210   = 4'd13;

    // alignment unit: dividend width, divisor width, remainder bits per stage
    localparam int ALIGN_DW  = 19;
    localparam int ALIGN_SW  = 13;
    localparam int ALIGN_BPS = 4;
    localparam int ALIGN_OW  = ALIGN_DW + 1;
    localparam int ALIGN_LAT = (ALIGN_DW + ALIGN_BPS - 1) / ALIGN_BPS + 1;

    // widths of aligned values as they enter the size stages
    localparam int STRIDE_W  = 19;
    localparam int CSTRIDE_W = 15;
    localparam int ROWS_W    = 16;
    localparam int CROWS_W   = 15;
    localparam int TOTAL_W   = 32;

    typedef struct packed {
        logic [3:0]  mode;
        logic [14:0] width;
        logic [14:0] height;
        logic [12:0] row_byte_align;
        logic [12:0] row_count_align;
    } t_req;

    typedef struct packed {
        logic        ok;
        logic [1:0]  plane_count;
        logic [17:0] stride_plane0;
        logic [15:0] stride_plane1;
        logic [14:0] stride_plane2;
        logic [29:0] offset_plane1;
        logic [29:0] offset_plane2;
        logic [31:0] total_bytes;
        logic [34:0] total_bits;
    } t_res;

    // per-item layout info that rides alongside the alignment units
    typedef struct packed {
        logic       ok;
        logic [1:0] planes;
        logic       chroma_w;   // planes one and two use the halved width
        logic       chroma_h;   // planes one and two use the halved height
    } t_meta;

endpackage

`default_nettype wire

// ----- sv/fplc_align.sv -----
// pipelined align-up unit: value rounded up to a multiple of align
// restoring remainder, a few bits per stage, then one add stage
// no dependencies; align must be nonzero
`default_nettype none

module fplc_align #(
    parameter int DW  = 19,
    parameter int SW  = 13,
    parameter int BPS = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [DW-1:0] i_value,
    input  wire logic [SW-1:0] i_align,
    output logic      [DW:0]   o_value
);

    localparam int NST = (DW + BPS - 1) / BPS;
    localparam int OW  = DW + 1;

    logic [SW-1:0] r_rem [NST];
    logic [DW-1:0] r_dvd [NST];
    logic [SW-1:0] r_aln [NST];
    logic [OW-1:0] r_out;

    for (genvar s = 0; s < NST; s++) begin : g_stage
        logic [SW-1:0] rem_in;
        logic [SW-1:0] n_rem;
        logic [DW-1:0] dvd_in;
        logic [DW-1:0] n_dvd;
        logic [SW-1:0] aln_in;
        logic [SW:0]   trial;

        if (s == 0) begin : g_first
            assign rem_in = '0;
            assign dvd_in = i_value;
            assign aln_in = i_align;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign dvd_in = r_dvd[s-1];
            assign aln_in = r_aln[s-1];
        end

        // dividend rotates so that after all steps it is back to the original value
        always_comb begin
            n_rem = rem_in;
            n_dvd = dvd_in;
            trial = '0;
            for (int j = 0; j < BPS; j++) begin
                if (s * BPS + j < DW) begin
                    trial = {n_rem, n_dvd[DW-1]};
                    if (trial >= {1'b0, aln_in}) begin
                        n_rem = SW'(trial - {1'b0, aln_in});
                    end else begin
                        n_rem = trial[SW-1:0];
                    end
                    n_dvd = {n_dvd[DW-2:0], n_dvd[DW-1]};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_dvd[s] <= n_dvd;
                r_aln[s] <= aln_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_rem[NST-1] == '0) begin
                r_out <= OW'(r_dvd[NST-1]);
            end else begin
                r_out <= OW'(r_dvd[NST-1]) + OW'(r_aln[NST-1] - r_rem[NST-1]);
            end
        end
    end

    assign o_value = r_out;

endmodule

`default_nettype wire

// ----- sv/fplc_size_calc.sv -----
// plane size products, offsets and totals, two register stages
// uses fplc_pkg for the metadata and result types
`default_nettype none

module fplc_size_calc (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire fplc_pkg::t_meta               i_meta,
    input  wire logic [fplc_pkg::STRIDE_W-1:0]  i_s0,
    input  wire logic [fplc_pkg::CSTRIDE_W-1:0] i_s1c,
    input  wire logic [fplc_pkg::ROWS_W-1:0]    i_ah,
    input  wire logic [fplc_pkg::CROWS_W-1:0]   i_ach,
    output logic                               o_valid,
    output fplc_pkg::t_res                     o_res
);

    localparam int PW = fplc_pkg::STRIDE_W + fplc_pkg::ROWS_W;

    logic [fplc_pkg::STRIDE_W-1:0] s1_sel;
    logic [fplc_pkg::ROWS_W-1:0]   h1_sel;
    logic [PW-1:0]                 p0;
    logic [PW-1:0]                 p1;

    logic                          r_a_valid;
    fplc_pkg::t_meta               r_a_meta;
    logic [fplc_pkg::STRIDE_W-1:0] r_a_s0;
    logic [fplc_pkg::STRIDE_W-1:0] r_a_s1;
    logic [fplc_pkg::TOTAL_W-1:0]  r_a_z0;
    logic [fplc_pkg::TOTAL_W-1:0]  r_a_z1;

    logic [fplc_pkg::TOTAL_W-1:0]  z1;
    logic [fplc_pkg::TOTAL_W-1:0]  z2;
    logic [fplc_pkg::TOTAL_W-1:0]  z01;
    logic [fplc_pkg::TOTAL_W-1:0]  total;
    fplc_pkg::t_res                n_res;

    logic                          r_b_valid;
    fplc_pkg::t_res                r_b_res;

    always_comb begin
        s1_sel = i_meta.chroma_w ? fplc_pkg::STRIDE_W'(i_s1c) : i_s0;
        h1_sel = i_meta.chroma_h ? fplc_pkg::ROWS_W'(i_ach) : i_ah;
        p0     = PW'(i_s0) * PW'(i_ah);
        p1     = PW'(s1_sel) * PW'(h1_sel);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_meta <= i_meta;
            r_a_s0   <= i_s0;
            r_a_s1   <= s1_sel;
            r_a_z0   <= p0[fplc_pkg::TOTAL_W-1:0];
            r_a_z1   <= p1[fplc_pkg::TOTAL_W-1:0];
        end
    end

    // plane two always matches plane one in size when present
    always_comb begin
        z1    = (r_a_meta.planes >= 2'd2) ? r_a_z1 : '0;
        z2    = (r_a_meta.planes == 2'd3) ? r_a_z1 : '0;
        z01   = r_a_z0 + z1;
        total = z01 + z2;
        n_res = '0;
        if (r_a_meta.ok) begin
            n_res.ok            = 1'b1;
            n_res.plane_count   = r_a_meta.planes;
            n_res.stride_plane0 = r_a_s0[17:0];
            if (r_a_meta.planes >= 2'd2) begin
                n_res.stride_plane1 = r_a_s1[15:0];
                n_res.offset_plane1 = r_a_z0[29:0];
            end
            if (r_a_meta.planes == 2'd3) begin
                n_res.stride_plane2 = r_a_s1[14:0];
                n_res.offset_plane2 = z01[29:0];
            end
            n_res.total_bytes = total;
            n_res.total_bits  = {total, 3'b000};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_res <= n_res;
        end
    end

    assign o_valid = r_b_valid;
    assign o_res   = r_b_res;

endmodule

`default_nettype wire

// ----- sv/fplc_skid.sv -----
// output register with one skid entry; the pipeline freezes only while the skid is full
// uses fplc_pkg for the result type
`default_nettype none

module fplc_skid (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire fplc_pkg::t_res i_res,
    input  wire logic           i_stall,
    output logic                o_valid,
    output fplc_pkg::t_res      o_res,
    output logic                o_full
);

    logic           r_out_valid;
    fplc_pkg::t_res r_out_res;
    logic           r_skid_valid;
    fplc_pkg::t_res r_skid_res;
    logic           out_free;

    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_valid;
            end
        end else if (!r_skid_valid && i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_res <= r_skid_valid ? r_skid_res : i_res;
        end
        if (!out_free && !r_skid_valid) begin
            r_skid_res <= i_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out_res;
    assign o_full  = r_skid_valid;

endmodule

`default_nettype wire

// ----- sv/frame_plane_layout_calc.sv -----
// frame buffer plane layout calculator, top level
// uses fplc_pkg, fplc_align, fplc_size_calc and fplc_skid
//
// A request item (format code, width, height, row byte alignment, row count
// alignment) enters on i_valid / o_stall / i_req; one result item (plane count,
// strides, plane offsets, total bytes and bits) leaves on o_valid / i_stall / o_res.
// Every request gives exactly one result, in order. Invalid requests (zero or
// oversized dimensions, oversized alignment, unknown format) give an all-zero result.
// Path: one decode stage, the align units (five remainder stages of up to
// four bits each plus the round-up add), two stages of products and sums, one output
// register. Throughput is one item per cycle as long as o_stall stays low.
// When the receiver stalls, the pipeline moves one more item into a skid entry and
// then raises o_stall until that entry drains; nothing is dropped or repeated.
// Reset (synchronous, active low) empties all stages; the block holds no other state.
`default_nettype none

module frame_plane_layout_calc #(
    parameter int MAX_DIM   = 16384,
    parameter int MAX_ALIGN = 4096
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire fplc_pkg::t_req i_req,
    output logic                o_valid,
    input  wire logic           i_stall,
    output fplc_pkg::t_res      o_res
);

    localparam int DW  = fplc_pkg::ALIGN_DW;
    localparam int SW  = fplc_pkg::ALIGN_SW;
    localparam int OW  = fplc_pkg::ALIGN_OW;
    localparam int LAT = fplc_pkg::ALIGN_LAT;

    logic en;
    logic skid_full;

    // decode
    logic            bad;
    fplc_pkg::t_meta n_meta;
    logic [DW-1:0]   n_rb;
    logic [15:0]     cw_sum;
    logic [15:0]     ch_sum;
    logic [SW-1:0]   n_ba;
    logic [SW-1:0]   n_ra;

    logic            r_s1_valid;
    fplc_pkg::t_meta r_s1_meta;
    logic [DW-1:0]   r_s1_rb;
    logic [DW-1:0]   r_s1_cw;
    logic [DW-1:0]   r_s1_h;
    logic [DW-1:0]   r_s1_ch;
    logic [SW-1:0]   r_s1_ba;
    logic [SW-1:0]   r_s1_ra;

    logic            r_mp_valid [LAT];
    fplc_pkg::t_meta r_mp_meta  [LAT];

    logic [OW-1:0]   al_s0;
    logic [OW-1:0]   al_s1c;
    logic [OW-1:0]   al_ah;
    logic [OW-1:0]   al_ach;

    logic            sz_valid;
    fplc_pkg::t_res  sz_res;

    assign en      = !skid_full;
    assign o_stall = skid_full;

    always_comb begin
        bad = (i_req.width == '0) || (i_req.height == '0) ||
              (32'(i_req.width) > MAX_DIM) || (32'(i_req.height) > MAX_DIM) ||
              (32'(i_req.row_byte_align) > MAX_ALIGN) ||
              (32'(i_req.row_count_align) > MAX_ALIGN);
        n_meta = '0;
        n_rb   = DW'(i_req.width);
        case (i_req.mode)
            fplc_pkg::FMT_RGB24, fplc_pkg::FMT_BGR24: begin
                n_meta.planes = 2'd1;
                n_rb = DW'({i_req.width, 1'b0}) + DW'(i_req.width);
            end
            fplc_pkg::FMT_ARGB32, fplc_pkg::FMT_ABGR32: begin
                n_meta.planes = 2'd1;
                n_rb = DW'({i_req.width, 2'b00});
            end
            fplc_pkg::FMT_Y416: begin
                n_meta.planes = 2'd1;
                n_rb = DW'({i_req.width, 3'b000});
            end
            fplc_pkg::FMT_YUY2, fplc_pkg::FMT_UYVY: begin
                n_meta.planes = 2'd1;
                n_rb = DW'({i_req.width, 1'b0});
            end
            fplc_pkg::FMT_Y800: begin
                n_meta.planes = 2'd1;
            end
            fplc_pkg::FMT_YV12, fplc_pkg::FMT_I420: begin
                n_meta.planes   = 2'd3;
                n_meta.chroma_w = 1'b1;
                n_meta.chroma_h = 1'b1;
            end
            fplc_pkg::FMT_YV24: begin
                n_meta.planes = 2'd3;
            end
            fplc_pkg::FMT_NV12: begin
                n_meta.planes   = 2'd2;
                n_meta.chroma_h = 1'b1;
            end
            fplc_pkg::FMT_P010: begin
                n_meta.planes   = 2'd2;
                n_meta.chroma_h = 1'b1;
                n_rb = DW'({i_req.width, 1'b0});
            end
            fplc_pkg::FMT_P210: begin
                n_meta.planes = 2'd2;
                n_rb = DW'({i_req.width, 1'b0});
            end
            default: begin
                bad = 1'b1;
            end
        endcase
        n_meta.ok = !bad;
        if (bad) begin
            n_meta.planes = 2'd0;
        end
        cw_sum = 16'(i_req.width) + 16'd1;
        ch_sum = 16'(i_req.height) + 16'd1;
        // zero alignment behaves as one, which leaves the value unchanged
        n_ba = (i_req.row_byte_align == '0) ? SW'(1) : i_req.row_byte_align;
        n_ra = (i_req.row_count_align == '0) ? SW'(1) : i_req.row_count_align;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_meta <= n_meta;
            r_s1_rb   <= n_rb;
            r_s1_cw   <= DW'(cw_sum[15:1]);
            r_s1_h    <= DW'(i_req.height);
            r_s1_ch   <= DW'(ch_sum[15:1]);
            r_s1_ba   <= n_ba;
            r_s1_ra   <= n_ra;
        end
    end

    // metadata travels beside the align units with the same latency
    for (genvar k = 0; k < LAT; k++) begin : g_meta
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_mp_valid[k] <= 1'b0;
            end else if (en) begin
                r_mp_valid[k] <= (k == 0) ? r_s1_valid : r_mp_valid[(k == 0) ? 0 : k - 1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_mp_meta[k] <= (k == 0) ? r_s1_meta : r_mp_meta[(k == 0) ? 0 : k - 1];
            end
        end
    end

    fplc_align #(.DW(DW), .SW(SW), .BPS(fplc_pkg::ALIGN_BPS)) u_align_s0 (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_value (r_s1_rb),
        .i_align (r_s1_ba),
        .o_value (al_s0)
    );

    fplc_align #(.DW(DW), .SW(SW), .BPS(fplc_pkg::ALIGN_BPS)) u_align_s1c (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_value (r_s1_cw),
        .i_align (r_s1_ba),
        .o_value (al_s1c)
    );

    fplc_align #(.DW(DW), .SW(SW), .BPS(fplc_pkg::ALIGN_BPS)) u_align_ah (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_value (r_s1_h),
        .i_align (r_s1_ra),
        .o_value (al_ah)
    );

    fplc_align #(.DW(DW), .SW(SW), .BPS(fplc_pkg::ALIGN_BPS)) u_align_ach (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_value (r_s1_ch),
        .i_align (r_s1_ra),
        .o_value (al_ach)
    );

    fplc_size_calc u_size (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_mp_valid[LAT-1]),
        .i_meta  (r_mp_meta[LAT-1]),
        .i_s0    (al_s0[fplc_pkg::STRIDE_W-1:0]),
        .i_s1c   (al_s1c[fplc_pkg::CSTRIDE_W-1:0]),
        .i_ah    (al_ah[fplc_pkg::ROWS_W-1:0]),
        .i_ach   (al_ach[fplc_pkg::CROWS_W-1:0]),
        .o_valid (sz_valid),
        .o_res   (sz_res)
    );

    fplc_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sz_valid),
        .i_res   (sz_res),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_res   (o_res),
        .o_full  (skid_full)
    );

endmodule

`default_nettype wire

// ----- sim/frame_plane_layout_calc_test.sv -----
// self-checking testbench for frame_plane_layout_calc: directed table, then random requests
// checks each result item against a local layout predictor or a given layout; depends on fplc_pkg and the rtl
`timescale 1ns / 100ps

module frame_plane_layout_calc_test;

    import fplc_pkg::*;

    localparam int DIM_LIMIT      = 16384;
    localparam int ALIGN_LIMIT    = 4096;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int PHASES         = 5;
    localparam int PHASE_ITEMS    = 390;

    // format codes the block must reject
    localparam logic [3:0] FMT_UNSUP_LO = 4'd14;
    localparam logic [3:0] FMT_UNSUP_HI = 4'd15;

    localparam t_res NO_LAYOUT = '0;

    typedef struct {
        t_req req;
        bit   typed;
        t_res want;
    } probe_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    t_req i_req   = '0;
    logic o_stall;
    logic o_valid;
    t_res o_res;

    t_res   layouts_due[$];
    probe_t probes[$];
    int     errors      = 0;
    bit     calm        = 1'b0;
    int     hold_left   = 0;
    int     quiet_count = 0;

    frame_plane_layout_calc u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (o_res)
    );

    always #10 i_clk = ~i_clk;

    function automatic longint unsigned round_up(longint unsigned v, longint unsigned a);
        if (a <= 1) return v;
        return ((v + a - 1) / a) * a;
    endfunction

    function automatic t_res layout_of(t_req r);
        longint unsigned w, h, ba, ra, rows, crows, cw;
        longint unsigned s0, s1, s2, z0, z1, z2, tot, bits;
        logic [1:0] planes;
        t_res res;
        res = '0;
        w = r.width;
        h = r.height;
        ba = r.row_byte_align;
        ra = r.row_count_align;
        if (w == 0 || h == 0 || w > DIM_LIMIT || h > DIM_LIMIT ||
            ba > ALIGN_LIMIT || ra > ALIGN_LIMIT || r.mode > FMT_P210)
            return res;
        rows = round_up(h, ra);
        crows = round_up((h + 1) / 2, ra);
        cw = (w + 1) / 2;
        s1 = 0;
        s2 = 0;
        z1 = 0;
        z2 = 0;
        case (r.mode)
            FMT_RGB24, FMT_BGR24: begin
                planes = 1; s0 = round_up(w * 3, ba); z0 = s0 * rows;
            end
            FMT_ARGB32, FMT_ABGR32: begin
                planes = 1; s0 = round_up(w * 4, ba); z0 = s0 * rows;
            end
            FMT_Y416: begin
                planes = 1; s0 = round_up(w * 8, ba); z0 = s0 * rows;
            end
            FMT_YUY2, FMT_UYVY: begin
                planes = 1; s0 = round_up(w * 2, ba); z0 = s0 * rows;
            end
            FMT_Y800: begin
                planes = 1; s0 = round_up(w, ba); z0 = s0 * rows;
            end
            FMT_YV12, FMT_I420: begin
                planes = 3; s0 = round_up(w, ba); s1 = round_up(cw, ba); s2 = s1;
                z0 = s0 * rows; z1 = s1 * crows; z2 = z1;
            end
            FMT_YV24: begin
                planes = 3; s0 = round_up(w, ba); s1 = s0; s2 = s0;
                z0 = s0 * rows; z1 = z0; z2 = z0;
            end
            FMT_NV12: begin
                planes = 2; s0 = round_up(w, ba); s1 = s0;
                z0 = s0 * rows; z1 = s1 * crows;
            end
            FMT_P010: begin
                planes = 2; s0 = round_up(w * 2, ba); s1 = s0;
                z0 = s0 * rows; z1 = s1 * crows;
            end
            default: begin
                planes = 2; s0 = round_up(w * 2, ba); s1 = s0;
                z0 = s0 * rows; z1 = s1 * rows;
            end
        endcase
        tot = z0 + z1 + z2;
        bits = tot * 8;
        res.ok = 1'b1;
        res.plane_count = planes;
        res.stride_plane0 = s0[17:0];
        res.stride_plane1 = s1[15:0];
        res.stride_plane2 = s2[14:0];
        if (planes >= 2) res.offset_plane1 = z0[29:0];
        if (planes >= 3) res.offset_plane2 = (z0 + z1) & 64'h3FFF_FFFF;
        res.total_bytes = tot[31:0];
        res.total_bits = bits[34:0];
        return res;
    endfunction

    function automatic t_req mk_req(logic [3:0] mode, int w, int h, int ba, int ra);
        t_req r;
        r.mode = mode;
        r.width = w;
        r.height = h;
        r.row_byte_align = ba;
        r.row_count_align = ra;
        return r;
    endfunction

    // single-plane layout that can be written down directly
    function automatic t_res mk_single(logic [17:0] stride, logic [31:0] total);
        t_res res;
        res = '0;
        res.ok = 1'b1;
        res.plane_count = 2'd1;
        res.stride_plane0 = stride;
        res.total_bytes = total;
        res.total_bits = {total, 3'b000};
        return res;
    endfunction

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [14:0] rand_dim();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return $urandom_range(1, 64);
        if (roll < 80) return $urandom_range(1, DIM_LIMIT);
        if (roll < 89) return $urandom_range(DIM_LIMIT - 8, DIM_LIMIT);
        if (roll < 97) return $urandom_range(1, 4);
        if (roll < 98) return 0;
        return $urandom_range(DIM_LIMIT + 1, 32767);
    endfunction

    function automatic logic [12:0] rand_align();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 20) return $urandom_range(0, 1);
        if (roll < 60) return 13'd1 << $urandom_range(1, 12);
        if (roll < 80) return $urandom_range(2, 64);
        if (roll < 98) return $urandom_range(0, ALIGN_LIMIT);
        return $urandom_range(ALIGN_LIMIT + 1, 8191);
    endfunction

    function automatic t_req rand_req();
        t_req r;
        r.mode = ($urandom_range(0, 99) < 96) ? $urandom_range(0, FMT_P210)
                                               : $urandom_range(FMT_UNSUP_LO, FMT_UNSUP_HI);
        r.width = rand_dim();
        r.height = rand_dim();
        r.row_byte_align = rand_align();
        r.row_count_align = rand_align();
        return r;
    endfunction

    task automatic push_req(input t_req r, input bit typed, input t_res want);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (o_stall);
        layouts_due.push_back(typed ? want : layout_of(r));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (layouts_due.size() != 0);
    endtask

    task automatic flag_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // receiver: check result items and stall at random
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (layouts_due.size() == 0) begin
                $error("result item with no request pending");
                errors++;
            end else begin
                want = layouts_due.pop_front();
                flag_field("ok", want.ok, o_res.ok);
                flag_field("plane_count", want.plane_count, o_res.plane_count);
                flag_field("stride_plane0", want.stride_plane0, o_res.stride_plane0);
                flag_field("stride_plane1", want.stride_plane1, o_res.stride_plane1);
                flag_field("stride_plane2", want.stride_plane2, o_res.stride_plane2);
                flag_field("offset_plane1", want.offset_plane1, o_res.offset_plane1);
                flag_field("offset_plane2", want.offset_plane2, o_res.offset_plane2);
                flag_field("total_bytes", want.total_bytes, o_res.total_bytes);
                flag_field("total_bits", want.total_bits, o_res.total_bits);
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            hold_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_count = 0;
        else
            quiet_count++;
        if (quiet_count >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        probes.push_back('{mk_req(FMT_Y800, 1, 1, 0, 0), 1'b1, mk_single(18'd1, 32'd1)});
        probes.push_back('{mk_req(FMT_Y416, DIM_LIMIT, DIM_LIMIT, 0, 0), 1'b1,
                           mk_single(18'd131072, 32'h8000_0000)});
        probes.push_back('{mk_req(FMT_RGB24, 640, 480, 64, 16), 1'b0, NO_LAYOUT});
        probes.push_back('{mk_req(FMT_BGR24, 1, DIM_LIMIT, 4096, 4096), 1'b0, NO_LAYOUT});
        probes.push_back('{mk_req(FMT_ARGB32, DIM_LIMIT, 1, 1, 1), 1'b0, NO_LAYOUT});
        probes.push_back('{mk_req(FMT_ABGR32, 3, 5, 3, 3), 1'b0, NO_LAYOUT});
        probes.push_back('{mk_req(FMT_YUY2, 1921, 1081, 128, 2), 1'b0, NO_LAYOUT});
        probes.push_back('{mk_req(FMT_UYVY, 2, 2, 0, 4096), 1'b0, NO_LAYOUT});
        probes.push_back('{mk_req(FMT_YV12, 17, 9, 0, 0), 1'b0, NO_LAYOUT});
        probes.push_back('{mk_req(FMT_I420, 1, 1, 4096, 4096), 1'b0, NO_LAYOUT});
        probes.push_back('{mk_req(FMT_YV24, DIM_LIMIT, DIM_LIMIT, 0, 0), 1'b0, NO_LAYOUT});
        probes.push_back('{mk_req(FMT_NV12, 1919, 1079, 16, 32), 1'b0, NO_LAYOUT});
        probes.push_back('{mk_req(FMT_P010, DIM_LIMIT, DIM_LIMIT, 4096, 4096), 1'b0,
                           NO_LAYOUT});
        probes.push_back('{mk_req(FMT_P210, 7, 3, 5, 7), 1'b0, NO_LAYOUT});
        probes.push_back('{mk_req(FMT_I420, DIM_LIMIT, DIM_LIMIT, 4095, 4095), 1'b0,
                           NO_LAYOUT});
        // rejected requests give an all-zero layout
        probes.push_back('{mk_req(FMT_RGB24, 0, 1, 0, 0), 1'b1, NO_LAYOUT});
        probes.push_back('{mk_req(FMT_Y800, 1, 0, 0, 0), 1'b1, NO_LAYOUT});
        probes.push_back('{mk_req(FMT_NV12, DIM_LIMIT + 1, 16, 0, 0), 1'b1, NO_LAYOUT});
        probes.push_back('{mk_req(FMT_YV12, 16, 32767, 0, 0), 1'b1, NO_LAYOUT});
        probes.push_back('{mk_req(FMT_Y416, 32767, 32767, 8191, 8191), 1'b1, NO_LAYOUT});
        probes.push_back('{mk_req(FMT_ARGB32, 64, 64, ALIGN_LIMIT + 1, 0), 1'b1, NO_LAYOUT});
        probes.push_back('{mk_req(FMT_YV24, 64, 64, 0, ALIGN_LIMIT + 1), 1'b1, NO_LAYOUT});
        probes.push_back('{mk_req(FMT_UNSUP_LO, 64, 64, 0, 0), 1'b1, NO_LAYOUT});
        probes.push_back('{mk_req(FMT_UNSUP_HI, DIM_LIMIT, DIM_LIMIT, 0, 0), 1'b1, NO_LAYOUT});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (probes[n])
            push_req(probes[n].req, probes[n].typed, probes[n].want);

        for (int phase = 0; phase < PHASES; phase++) begin
            calm = (phase == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
                push_req(rand_req(), 1'b0, NO_LAYOUT);
            // hold off the sender until the pipeline is empty
            if (phase == 1 || phase == 3)
                drain();
        end
        calm = 1'b0;

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
